@@ hdl/gfq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfq_pkg: shared codes and types for the grouped FIFO queue
// Command codes, status codes and the work item handed from the
// front (table side) to the back (queue side).
// ----------------------------------------------------------------------------
package gfq_pkg;

  // command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_ENQ  = 2'd1;
  localparam logic [1:0] CMD_DEQ  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_QFULL   = 3'd3;
  localparam logic [2:0] ST_TFULL   = 3'd4;

  localparam int ID_W  = 16;
  localparam int GRP_W = 8;

  // classified command passed from front to back
  typedef struct packed {
    logic [1:0]       cmd;
    logic [ID_W-1:0]  id;
    logic [GRP_W-1:0] grp;
    logic [2:0]       status;
  } gfq_item_t;

endpackage

`default_nettype wire

@@ hdl/gfq_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfq_fifo: two-entry item queue
// Decouples the table front from the queue back so each side stalls
// on its own.
// ----------------------------------------------------------------------------
module gfq_fifo
  import gfq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire gfq_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           empty,
  output gfq_item_t      head
);

  gfq_item_t  mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/gfq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfq_front: command intake and member table
// Accepts commands, loads the member table, resolves an enqueued
// member to its group and pushes a classified item to the back.
// ----------------------------------------------------------------------------
module gfq_front
  import gfq_pkg::*;
#(
  parameter int MAX_MEMBERS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       command,
  input  wire logic [ID_W-1:0]  member_id,
  input  wire logic [GRP_W-1:0] group_id,
  input  wire logic             fifo_full,
  output logic                  push,
  output gfq_item_t             push_item
);

  localparam int TCW = $clog2(MAX_MEMBERS + 1);
  localparam int TIW = $clog2(MAX_MEMBERS);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_PICK = 1'b1;

  logic                   state;
  logic [TCW-1:0]         tcount;
  logic [ID_W-1:0]        tid  [MAX_MEMBERS];
  logic [GRP_W-1:0]       tgrp [MAX_MEMBERS];
  logic [MAX_MEMBERS-1:0] match;
  logic [MAX_MEMBERS-1:0] match_now;
  logic [MAX_MEMBERS-1:0] first_hit;
  logic [GRP_W-1:0]       hit_grp;
  logic [ID_W-1:0]        enq_id;
  logic                   accept;
  logic                   tfull;

  assign busy   = (state != F_IDLE) || fifo_full;
  assign accept = start && !busy;
  assign tfull  = (tcount == TCW'(MAX_MEMBERS));

  // per-entry compare against the incoming member
  always_comb begin
    for (int i = 0; i < MAX_MEMBERS; i++) begin
      match_now[i] = (TCW'(i) < tcount) && (tid[i] == member_id);
    end
  end

  // oldest matching entry wins
  assign first_hit = match & (~match + MAX_MEMBERS'(1));

  always_comb begin
    hit_grp = '0;
    for (int i = 0; i < MAX_MEMBERS; i++) begin
      hit_grp = hit_grp | ({GRP_W{first_hit[i]}} & tgrp[i]);
    end
  end

  // item toward the back
  always_comb begin
    push           = 1'b0;
    push_item.cmd  = command;
    push_item.id   = member_id;
    push_item.grp  = group_id;
    push_item.status = ST_OK;
    case (state)
      F_IDLE: begin
        if (accept && command != CMD_ENQ) begin
          push = 1'b1;
          if (command == CMD_LOAD && tfull) begin
            push_item.status = ST_TFULL;
          end
        end
      end
      F_PICK: begin
        push          = 1'b1;
        push_item.cmd = CMD_ENQ;
        push_item.id  = enq_id;
        push_item.grp = hit_grp;
        if (match == '0) begin
          push_item.status = ST_UNKNOWN;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // table storage and lookup registers
  always_ff @(posedge clk) begin
    if (accept && command == CMD_LOAD && !tfull) begin
      tid[tcount[TIW-1:0]]  <= member_id;
      tgrp[tcount[TIW-1:0]] <= group_id;
    end
    if (accept && command == CMD_ENQ) begin
      match  <= match_now;
      enq_id <= member_id;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      tcount <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (command == CMD_ENQ) begin
              state <= F_PICK;
            end else if (command == CMD_LOAD && !tfull) begin
              tcount <= tcount + TCW'(1);
            end
          end
        end
        F_PICK: begin
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/gfq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfq_back: grouped queue cell chain
// Holds the queue as a row of cells; performs grouped insert and head
// removal and drives the result beat.
// ----------------------------------------------------------------------------
module gfq_back
  import gfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_avail,
  input  wire gfq_item_t   item,
  output logic             item_pop,
  output logic             done,
  output logic [ID_W-1:0]  out_member,
  output logic             out_valid,
  output logic [2:0]       status
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_INS  = 1'b1;

  logic                   state;
  logic [QCW-1:0]         qcount;
  logic [ID_W-1:0]        qid  [QUEUE_DEPTH];
  logic [GRP_W-1:0]       qgrp [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] eq_vec;
  logic [QUEUE_DEPTH-1:0] eq_now;
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] first_free;
  logic [QUEUE_DEPTH-1:0] grp_end;
  logic [QUEUE_DEPTH-1:0] end_dec;
  logic [QUEUE_DEPTH-1:0] after;
  logic [QUEUE_DEPTH-1:0] ins_sel;
  logic [QUEUE_DEPTH-1:0] shift_sel;
  logic [ID_W-1:0]        ins_id;
  logic [GRP_W-1:0]       ins_grp;
  logic                   qfull;
  logic                   qempty;
  logic                   do_deq;
  logic                   go_ins;

  assign qfull    = (qcount == QCW'(QUEUE_DEPTH));
  assign qempty   = (qcount == '0);
  assign item_pop = (state == B_IDLE) && item_avail;
  assign do_deq   = item_pop && item.cmd == CMD_DEQ && !qempty;
  assign go_ins   = item_pop && item.cmd == CMD_ENQ && item.status == ST_OK && !qfull;

  // occupancy, first free cell and group compare per cell
  always_comb begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      occ[j]    = (QCW'(j) < qcount);
      eq_now[j] = occ[j] && (qgrp[j] == item.grp);
    end
    first_free[0] = !occ[0];
    for (int j = 1; j < QUEUE_DEPTH; j++) begin
      first_free[j] = !occ[j] && occ[j-1];
    end
  end

  // last cell of the group: the cell past the tail counts as different
  always_comb begin
    for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
      grp_end[j] = eq_vec[j] && !eq_vec[j+1];
    end
    grp_end[QUEUE_DEPTH-1] = eq_vec[QUEUE_DEPTH-1];
  end

  // cells past the group end shift up; the cell just after it takes the new entry
  assign end_dec   = {grp_end[QUEUE_DEPTH-2:0], 1'b0} - QUEUE_DEPTH'(1);
  assign after     = ~end_dec;
  assign ins_sel   = (grp_end != '0) ? {grp_end[QUEUE_DEPTH-2:0], 1'b0} : first_free;
  assign shift_sel = after & ~ins_sel;

  // cell storage
  always_ff @(posedge clk) begin
    if (do_deq) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        qid[j]  <= qid[j+1];
        qgrp[j] <= qgrp[j+1];
      end
    end else if (state == B_INS) begin
      // the head cell never shifts, it can only take the new entry
      if (ins_sel[0]) begin
        qid[0]  <= ins_id;
        qgrp[0] <= ins_grp;
      end
      for (int j = 1; j < QUEUE_DEPTH; j++) begin
        if (ins_sel[j]) begin
          qid[j]  <= ins_id;
          qgrp[j] <= ins_grp;
        end else if (shift_sel[j]) begin
          qid[j]  <= qid[j-1];
          qgrp[j] <= qgrp[j-1];
        end
      end
    end
    if (go_ins) begin
      eq_vec  <= eq_now;
      ins_id  <= item.id;
      ins_grp <= item.grp;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (item_pop) begin
      out_member <= '0;
      out_valid  <= 1'b0;
      status     <= item.status;
      case (item.cmd)
        CMD_ENQ: begin
          if (item.status == ST_OK && qfull) begin
            status <= ST_QFULL;
          end
        end
        CMD_DEQ: begin
          if (qempty) begin
            status <= ST_EMPTY;
          end else begin
            out_member <= qid[0];
            out_valid  <= 1'b1;
            status     <= ST_OK;
          end
        end
        default: begin
          status <= item.status;
        end
      endcase
    end else if (state == B_INS) begin
      out_member <= '0;
      out_valid  <= 1'b0;
      status     <= ST_OK;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      qcount <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_IDLE: begin
          if (go_ins) begin
            state <= B_INS;
          end else if (item_pop) begin
            done <= 1'b1;
            if (do_deq) begin
              qcount <= qcount - QCW'(1);
            end
          end
        end
        B_INS: begin
          done   <= 1'b1;
          qcount <= qcount + QCW'(1);
          state  <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/grouped_fifo_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_fifo_queue: grouped FIFO (team queue)
// Member table plus a queue that keeps entries of one group together.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command
// gives exactly one result beat, shown for a single cycle with done high;
// the receiver must take it then, as the block never waits. Results come
// out in command order. The front handles load, dequeue and the unused
// code directly, and enqueue in two steps (table compare, then
// oldest-match pick), so busy is high in the cycle after an enqueue is
// taken. The back handles other items directly, and an inserting enqueue
// in two steps (group compare, then shift insert in the cell chain). A
// two-entry queue sits between them; busy also rises while it is full.
// Commands other than enqueue are taken at one per cycle while that
// queue is not full; an enqueue holds off the next command until its pick
// is done. The table and queue need no clearing after reset.
// ----------------------------------------------------------------------------
module grouped_fifo_queue
  import gfq_pkg::*;
#(
  parameter int MAX_MEMBERS = 64,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       command,
  input  wire logic [ID_W-1:0]  member_id,
  input  wire logic [GRP_W-1:0] group_id,
  output logic                  done,
  output logic [ID_W-1:0]       out_member,
  output logic                  out_valid,
  output logic [2:0]            status
);

  logic      fifo_full;
  logic      fifo_empty;
  logic      push;
  logic      pop;
  gfq_item_t push_item;
  gfq_item_t head;

  // command intake and member table
  gfq_front #(
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .member_id (member_id),
    .group_id  (group_id),
    .fifo_full (fifo_full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  gfq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .empty     (fifo_empty),
    .head      (head)
  );

  // grouped queue cells and result beat
  gfq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_avail (!fifo_empty),
    .item       (head),
    .item_pop   (pop),
    .done       (done),
    .out_member (out_member),
    .out_valid  (out_valid),
    .status     (status)
  );

endmodule

`default_nettype wire

@@ sim/tb_grouped_fifo_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grouped_fifo_queue: self-checking bench for the grouped FIFO queue
// Drives load, enqueue, dequeue and unused commands through the start/busy
// handshake and compares every result beat against an in-bench model of the
// member table and the grouped queue. Covers the corner cases, a full table
// and queue, and a long random mix with and without idle gaps.
// ----------------------------------------------------------------------------
module tb_grouped_fifo_queue;
  import gfq_pkg::*;

  localparam int         MAX_MEMBERS    = 64;
  localparam int         QUEUE_DEPTH    = 64;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 500;
  localparam int         RANDOM_ROUNDS  = 4;
  localparam int         ROUND_ITEMS    = 425;
  localparam int         ERROR_CAP      = 50;

  // one result beat
  typedef struct packed {
    logic [ID_W-1:0] member;
    logic            valid;
    logic [2:0]      status;
  } result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       command = CMD_LOAD;
  logic [ID_W-1:0]  member_id = '0;
  logic [GRP_W-1:0] group_id = '0;
  logic             busy;
  logic             done;
  logic [ID_W-1:0]  out_member;
  logic             out_valid;
  logic [2:0]       status;

  // model state: member roster and the grouped line
  logic [ID_W-1:0]  roster_id  [MAX_MEMBERS];
  logic [GRP_W-1:0] roster_grp [MAX_MEMBERS];
  int               roster_len = 0;
  logic [ID_W-1:0]  line_id    [QUEUE_DEPTH];
  logic [GRP_W-1:0] line_grp   [QUEUE_DEPTH];
  int               line_len = 0;

  result_t pending_results [$];
  result_t head;
  int      gap_limit = 0;
  int      idle_cycles = 0;
  int      fail_count = 0;
  int      beats_sent = 0;
  int      beats_checked = 0;
  int      members_served = 0;
  int      empty_hits = 0;
  int      unknown_hits = 0;
  int      line_full_hits = 0;
  int      roster_full_hits = 0;

  logic [GRP_W-1:0] team_pool [6] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd128, 8'd77};

  grouped_fifo_queue #(
    .MAX_MEMBERS(MAX_MEMBERS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .member_id(member_id),
    .group_id(group_id),
    .done(done),
    .out_member(out_member),
    .out_valid(out_valid),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of one command: updates roster/line and returns the result beat
  function automatic result_t apply_command(input logic [1:0] cmd,
                                            input logic [ID_W-1:0] id,
                                            input logic [GRP_W-1:0] grp);
    result_t          r;
    int               hit;
    int               slot;
    int               k;
    bit               placed;
    logic [GRP_W-1:0] team;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_LOAD: begin
        if (roster_len >= MAX_MEMBERS) begin
          r.status = ST_TFULL;
        end else begin
          roster_id[roster_len] = id;
          roster_grp[roster_len] = grp;
          roster_len++;
        end
      end
      CMD_ENQ: begin
        // oldest roster entry wins on duplicates
        hit = -1;
        for (k = 0; k < roster_len; k++)
          if (hit < 0 && roster_id[k] == id) hit = k;
        if (hit < 0) begin
          r.status = ST_UNKNOWN;
        end else if (line_len >= QUEUE_DEPTH) begin
          r.status = ST_QFULL;
        end else begin
          team = roster_grp[hit];
          slot = line_len;
          placed = 1'b0;
          // land right after the last entry of this group's run
          for (k = 0; k < line_len; k++) begin
            if (!placed && line_grp[k] == team &&
                (k + 1 >= line_len || line_grp[k+1] != team)) begin
              slot = k + 1;
              placed = 1'b1;
            end
          end
          for (k = line_len; k > slot; k--) begin
            line_id[k] = line_id[k-1];
            line_grp[k] = line_grp[k-1];
          end
          line_id[slot] = id;
          line_grp[slot] = team;
          line_len++;
        end
      end
      CMD_DEQ: begin
        if (line_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.member = line_id[0];
          r.valid = 1'b1;
          for (k = 0; k + 1 < line_len; k++) begin
            line_id[k] = line_id[k+1];
            line_grp[k] = line_grp[k+1];
          end
          line_len--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit on_roster(input logic [ID_W-1:0] id);
    for (int k = 0; k < roster_len; k++)
      if (roster_id[k] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [ID_W-1:0] stranger_id();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom); while (on_roster(id));
    return id;
  endfunction

  function automatic logic [ID_W-1:0] known_id();
    return roster_id[$urandom_range(roster_len - 1, 0)];
  endfunction

  function automatic logic [GRP_W-1:0] pick_team();
    if ($urandom_range(4, 0) == 0) return GRP_W'($urandom);
    return team_pool[$urandom_range(5, 0)];
  endfunction

  // Send one command beat; start stays high across back-to-back beats
  task automatic send_beat(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [GRP_W-1:0] grp);
    int      gap;
    result_t want;
    gap = $urandom_range(gap_limit, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    member_id <= id;
    group_id <= grp;
    do @(posedge clk); while (busy !== 1'b0);
    want = apply_command(cmd, id, grp);
    pending_results = {pending_results, want};
    beats_sent++;
    case (want.status)
      ST_EMPTY:   empty_hits++;
      ST_UNKNOWN: unknown_hits++;
      ST_QFULL:   line_full_hits++;
      ST_TFULL:   roster_full_hits++;
      default:    if (want.valid) members_served++;
    endcase
  endtask

  // empty line, empty roster and the unused code
  task automatic test_empty_cases();
    gap_limit = 3;
    send_beat(CMD_DEQ, 16'h0000, 8'h00);
    send_beat(CMD_ENQ, 16'hFFFF, 8'hFF);
    send_beat(CMD_UNUSED, 16'hA5A5, 8'h5A);
  endtask

  // field extremes, duplicate load, grouping and order
  task automatic test_extremes();
    gap_limit = 0;
    send_beat(CMD_LOAD, 16'h0000, 8'h00);
    send_beat(CMD_LOAD, 16'hFFFF, 8'hFF);
    send_beat(CMD_LOAD, 16'h1234, 8'hFF);
    send_beat(CMD_LOAD, 16'h0000, 8'h07);   // duplicate: first entry wins
    send_beat(CMD_ENQ, 16'hFFFF, 8'h00);
    send_beat(CMD_ENQ, 16'h0000, 8'hFF);
    send_beat(CMD_ENQ, 16'h1234, 8'h00);    // joins the 255 run mid-line
    send_beat(CMD_ENQ, 16'h0000, 8'h00);    // joins the 0 run at the tail
    send_beat(CMD_ENQ, 16'h5555, 8'h00);    // not on roster
    send_beat(CMD_UNUSED, 16'hFFFF, 8'hFF);
    repeat (5) send_beat(CMD_DEQ, 16'hFFFF, 8'hFF);
  endtask

  // fill the roster, then overflow it
  task automatic test_roster_fill();
    gap_limit = 6;
    while (roster_len < MAX_MEMBERS) begin
      if ($urandom_range(9, 0) == 0) send_beat(CMD_LOAD, known_id(), pick_team());
      else send_beat(CMD_LOAD, ID_W'($urandom), pick_team());
    end
    repeat (3) send_beat(CMD_LOAD, ID_W'($urandom), GRP_W'($urandom));
  endtask

  // fill the line, overflow it, unknown beats full, then drain past empty
  task automatic test_line_full();
    gap_limit = 2;
    while (line_len < QUEUE_DEPTH) send_beat(CMD_ENQ, known_id(), GRP_W'($urandom));
    send_beat(CMD_ENQ, known_id(), GRP_W'($urandom));
    send_beat(CMD_ENQ, stranger_id(), GRP_W'($urandom));
    send_beat(CMD_ENQ, known_id(), GRP_W'($urandom));
    while (line_len > 0) send_beat(CMD_DEQ, ID_W'($urandom), GRP_W'($urandom));
    send_beat(CMD_DEQ, ID_W'($urandom), GRP_W'($urandom));
  endtask

  // random mix, alternating enqueue- and dequeue-heavy rounds
  task automatic test_random_mix();
    int pick;
    int enq_share;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      enq_share = (round % 2 == 0) ? 58 : 32;
      gap_limit = (round == 1) ? 0 : (round == 3) ? 4 : 19;
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        pick = $urandom_range(99, 0);
        if (pick < enq_share) send_beat(CMD_ENQ, known_id(), GRP_W'($urandom));
        else if (pick < 87) send_beat(CMD_DEQ, ID_W'($urandom), GRP_W'($urandom));
        else if (pick < 92) send_beat(CMD_ENQ, ID_W'($urandom), GRP_W'($urandom));
        else if (pick < 96) send_beat(CMD_LOAD, ID_W'($urandom), GRP_W'($urandom));
        else send_beat(CMD_UNUSED, ID_W'($urandom), GRP_W'($urandom));
      end
    end
  endtask

  // result checker: every done beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= ERROR_CAP)
          $error("unexpected result beat: out_member %0d out_valid %0d status %0d",
                 out_member, out_valid, status);
      end else begin
        head = pending_results.pop_front();
        beats_checked++;
        if (out_member !== head.member) begin
          fail_count++;
          if (fail_count <= ERROR_CAP)
            $error("out_member: expected %0d, got %0d", head.member, out_member);
        end
        if (out_valid !== head.valid) begin
          fail_count++;
          if (fail_count <= ERROR_CAP)
            $error("out_valid: expected %0d, got %0d", head.valid, out_valid);
        end
        if (status !== head.status) begin
          fail_count++;
          if (fail_count <= ERROR_CAP)
            $error("status: expected %0d, got %0d", head.status, status);
        end
      end
    end
  end

  // watchdog: too long with no command or result beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[grouped_fifo_queue] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_cases();
    test_extremes();
    test_roster_fill();
    test_line_full();
    test_random_mix();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d commands, checked %0d results; %0d members dequeued.",
             beats_sent, beats_checked, members_served);
    $display("Status hits: empty %0d, unknown %0d, queue full %0d, table full %0d.",
             empty_hits, unknown_hits, line_full_hits, roster_full_hits);
    if (fail_count == 0) begin
      $display("[grouped_fifo_queue] OK");
    end else begin
      $display("[grouped_fifo_queue] ERROR");
    end
    $finish;
  end

endmodule
